### rtl/core/modular_exponentiation_unit_macros.svh
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MEU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular exponentiation check failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular exponentiation check failed");

`endif

### rtl/core/meu_pkg.sv
package meu_pkg;

  localparam int WIDTH       = 32;
  localparam int CNT_W       = $clog2(WIDTH);
  localparam int IN_TDATA_W  = ((3 * WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WIDTH + 7) / 8) * 8;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam word_t WORD_ONE = word_t'(1);

  typedef enum logic [1:0] {
    B_BASE,
    B_R,
    B_GR
  } bsel_t;

  typedef enum logic [1:0] {
    RES_R,
    RES_ONE,
    RES_ZERO
  } osel_t;

  typedef struct packed {
    logic  load;
    logic  init_r;
    logic  mul_start;
    bsel_t b_sel;
    logic  dbl;
    logic  add;
    logic  shift_b;
    logic  store_gr;
    logic  store_r;
    logic  shift_e;
    logic  out_load;
    osel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
    logic b_msb;
    logic e_msb;
  } status_t;

endpackage

### rtl/core/meu_dpath.sv
module meu_dpath import meu_pkg::*; (
  input  logic    clk,
  input  cmd_t    cmd,
  input  word_t   base,
  input  word_t   exponent,
  input  word_t   modulus,
  output status_t status,
  output word_t   power_mod
);

  word_t base_r;
  word_t exp_r;
  word_t mod_r;
  word_t r_r;
  word_t gr_r;
  word_t acc_r;
  word_t b_r;
  word_t out_data_r;

  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] diff;
  word_t            addend;
  word_t            acc_nxt;
  word_t            b_nxt;

  // Both operands are below the modulus, so one conditional subtract reduces the sum.
  always_comb begin
    addend = cmd.add ? r_r : acc_r;
    sum    = {1'b0, acc_r} + {1'b0, addend};
    diff   = {1'b0, sum} - {2'b00, mod_r};
    acc_nxt = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
  end

  always_comb begin
    case (cmd.b_sel)
      B_BASE:  b_nxt = base_r;
      B_R:     b_nxt = r_r;
      B_GR:    b_nxt = gr_r;
      default: b_nxt = base_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base;
      exp_r  <= exponent;
      mod_r  <= modulus;
    end
    if (cmd.init_r) begin
      r_r <= (mod_r == WORD_ONE) ? '0 : WORD_ONE;
    end
    if (cmd.mul_start) begin
      acc_r <= '0;
      b_r   <= b_nxt;
    end
    if (cmd.dbl || cmd.add) begin
      acc_r <= acc_nxt;
    end
    if (cmd.shift_b) begin
      b_r <= {b_r[WIDTH-2:0], 1'b0};
    end
    if (cmd.store_gr) begin
      gr_r <= acc_r;
    end
    if (cmd.store_r) begin
      r_r <= acc_r;
    end
    if (cmd.shift_e) begin
      exp_r <= {exp_r[WIDTH-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        RES_R:    out_data_r <= r_r;
        RES_ONE:  out_data_r <= WORD_ONE;
        RES_ZERO: out_data_r <= '0;
        default:  out_data_r <= '0;
      endcase
    end
  end

  assign status.exp_zero = (exp_r == '0);
  assign status.mod_zero = (mod_r == '0);
  assign status.b_msb    = b_r[WIDTH-1];
  assign status.e_msb    = exp_r[WIDTH-1];
  assign power_mod       = out_data_r;

endmodule

### rtl/core/meu_ctrl.sv
module meu_ctrl import meu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MSTART,
    ST_MDBL,
    ST_MADD,
    ST_MDONE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_GR,
    PH_SQR,
    PH_MUL
  } phase_t;

  state_t state_r;
  phase_t phase_r;
  cnt_t   mcnt_r;
  cnt_t   ecnt_r;
  osel_t  res_sel_r;
  logic   out_tvalid_r;
  logic   out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd = '0;
    cmd.b_sel   = B_BASE;
    cmd.out_sel = res_sel_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_tvalid;
      end
      ST_CHECK: begin
        cmd.init_r = !status.exp_zero && !status.mod_zero;
      end
      ST_MSTART: begin
        cmd.mul_start = 1'b1;
        case (phase_r)
          PH_GR:   cmd.b_sel = B_BASE;
          PH_SQR:  cmd.b_sel = B_R;
          PH_MUL:  cmd.b_sel = B_GR;
          default: cmd.b_sel = B_BASE;
        endcase
      end
      ST_MDBL: begin
        cmd.dbl     = 1'b1;
        cmd.shift_b = !status.b_msb;
      end
      ST_MADD: begin
        cmd.add     = 1'b1;
        cmd.shift_b = 1'b1;
      end
      ST_MDONE: begin
        cmd.store_gr = (phase_r == PH_GR);
        cmd.store_r  = (phase_r != PH_GR);
        cmd.shift_e  = (phase_r == PH_MUL) || (phase_r == PH_SQR && !status.e_msb);
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_GR;
      mcnt_r       <= '0;
      ecnt_r       <= '0;
      res_sel_r    <= RES_R;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != ST_FINISH)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (status.exp_zero) begin
            res_sel_r <= RES_ONE;
            state_r   <= ST_FINISH;
          end else if (status.mod_zero) begin
            res_sel_r <= RES_ZERO;
            state_r   <= ST_FINISH;
          end else begin
            res_sel_r <= RES_R;
            phase_r   <= PH_GR;
            ecnt_r    <= cnt_t'(WIDTH - 1);
            state_r   <= ST_MSTART;
          end
        end
        ST_MSTART: begin
          mcnt_r  <= cnt_t'(WIDTH - 1);
          state_r <= ST_MDBL;
        end
        ST_MDBL: begin
          if (status.b_msb) begin
            state_r <= ST_MADD;
          end else if (mcnt_r == '0) begin
            state_r <= ST_MDONE;
          end else begin
            mcnt_r <= mcnt_r - 1'b1;
          end
        end
        ST_MADD: begin
          if (mcnt_r == '0) begin
            state_r <= ST_MDONE;
          end else begin
            mcnt_r  <= mcnt_r - 1'b1;
            state_r <= ST_MDBL;
          end
        end
        ST_MDONE: begin
          case (phase_r)
            PH_GR: begin
              phase_r <= PH_SQR;
              state_r <= ST_MSTART;
            end
            PH_SQR: begin
              if (status.e_msb) begin
                phase_r <= PH_MUL;
                state_r <= ST_MSTART;
              end else if (ecnt_r == '0) begin
                state_r <= ST_FINISH;
              end else begin
                ecnt_r  <= ecnt_r - 1'b1;
                state_r <= ST_MSTART;
              end
            end
            PH_MUL: begin
              phase_r <= PH_SQR;
              if (ecnt_r == '0) begin
                state_r <= ST_FINISH;
              end else begin
                ecnt_r  <= ecnt_r - 1'b1;
                state_r <= ST_MSTART;
              end
            end
            default: begin
              state_r <= ST_IDLE;
            end
          endcase
        end
        ST_FINISH: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/modular_exponentiation_unit.sv
// Channel  Direction  Ports              Contents
// in       slave      in_tvalid/tready   base, exponent, modulus
// out      master     out_tvalid/tready  power_mod
//
// A zero exponent or zero modulus skips the arithmetic. Other requests run on the shared
// modular adder, one add and reduce per cycle while a product is formed, stepped over
// each multiplier bit of every square and multiply.
// Reset is synchronous and active low; it clears the controller and the output valid.
// A new request is taken while a finished result still waits in the output register.
`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit import meu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // base, exponent, modulus
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // power_mod
);

  cmd_t    cmd;
  status_t status;
  word_t   power_mod;

  meu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  meu_dpath u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .base      (in_tdata[WIDTH-1:0]),
    .exponent  (in_tdata[2*WIDTH-1:WIDTH]),
    .modulus   (in_tdata[3*WIDTH-1:2*WIDTH]),
    .status    (status),
    .power_mod (power_mod)
  );

  assign out_tdata = OUT_TDATA_W'(power_mod);

  `MEU_ASSERT_NOW(a_idle_no_arith, in_tready, !(cmd.dbl || cmd.add))
  `MEU_ASSERT_NOW(a_no_overwrite, out_tvalid && !out_tready, !cmd.out_load)
  `MEU_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready)

endmodule

### tb/sv/modexp_checker.sv
module modexp_checker import meu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     pending,
  output int                     checked
);

  typedef struct packed {
    word_t base;
    word_t exponent;
    word_t modulus;
    word_t power;
  } modexp_req_t;

  modexp_req_t expected_powers[$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic word_t power_mod_of(word_t base, word_t exponent, word_t modulus);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] reduced_base;
    if (exponent == '0) begin
      return WORD_ONE;
    end
    if (modulus == '0) begin
      return '0;
    end
    reduced_base = base % modulus;
    acc = WORD_ONE % modulus;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % modulus;
      if (exponent[i]) begin
        acc = (acc * reduced_base) % modulus;
      end
    end
    return word_t'(acc);
  endfunction

  always @(posedge clk) begin
    modexp_req_t req;
    modexp_req_t head;
    word_t       actual;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        actual = out_tdata[WIDTH-1:0];
        if (expected_powers.size() == 0) begin
          if (mismatches < 10) begin
            $display("Unexpected result %h with no request outstanding", actual);
          end
          mismatches = mismatches + 1;
        end else begin
          head = expected_powers.pop_front();
          checked = checked + 1;
          if (actual !== head.power) begin
            if (mismatches < 10) begin
              $display("power_mod mismatch: base %h exponent %h modulus %h expected %h actual %h",
                       head.base, head.exponent, head.modulus, head.power, actual);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        req.base     = in_tdata[WIDTH-1:0];
        req.exponent = in_tdata[2*WIDTH-1:WIDTH];
        req.modulus  = in_tdata[3*WIDTH-1:2*WIDTH];
        req.power    = power_mod_of(req.base, req.exponent, req.modulus);
        expected_powers.push_back(req);
      end
    end
    pending <= expected_powers.size();
  end

endmodule

### tb/sv/tb_modular_exponentiation_unit.sv
module tb_modular_exponentiation_unit;
  import meu_pkg::*;

  localparam int     HALF_PERIOD     = 6;
  localparam int     RANDOM_REQUESTS = 121;
  localparam longint CYCLE_LIMIT     = 3_000_000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int     mismatches;
  int     pending;
  int     checked;
  int     sent         = 0;
  int     directed     = 0;
  bit     ready_idling = 1'b1;
  int     stall_left   = 0;
  longint cycle_count  = 0;

  always #HALF_PERIOD clk = ~clk;

  modular_exponentiation_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  modexp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (ready_idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(input word_t base, input word_t exponent,
                              input word_t modulus, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {modulus, exponent, base};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return word_t'($urandom_range(0, 15));
      1: return '1 - word_t'($urandom_range(0, 15));
      2: return WORD_ONE << $urandom_range(0, WIDTH - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    word_t base;
    word_t exponent;
    word_t modulus;
    bit    busy_phase;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_request(32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_request(32'h0000_0005, 32'h0000_0000, 32'h0000_0001, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_request(32'h0000_0007, 32'h0000_0001, 32'h0000_0000, 1'b1);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_request(32'h1234_5678, 32'h0000_0005, 32'h0000_0001, 1'b1);
    send_request(32'h0000_0000, 32'h0000_0001, 32'h0000_0007, 1'b1);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 1'b1);
    send_request(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, 1'b1);
    send_request(32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b1);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(32'h0000_0005, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_request(32'h075B_CD15, 32'h0000_0001, 32'h0000_03E8, 1'b1);
    send_request(32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0000, 1'b1);
    send_request(32'hDEAD_BEEF, 32'h1234_5678, 32'h7FFF_FFFF, 1'b1);
    send_request(32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 1'b1);
    directed = sent;

    // Let every outstanding request complete before the random traffic starts.
    in_tvalid <= 1'b0;
    drain_results();

    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      busy_phase   = !(k >= 50 && k < 70) && (k < RANDOM_REQUESTS - 20);
      ready_idling <= busy_phase;
      base     = pick_word();
      exponent = ($urandom_range(0, 19) == 0) ? word_t'(0) : pick_word();
      modulus  = ($urandom_range(0, 29) == 0) ? word_t'(0) : pick_word();
      send_request(base, exponent, modulus, busy_phase);
    end
    in_tvalid <= 1'b0;

    drain_results();
    repeat (16) @(posedge clk);

    $display("Sent %0d requests (%0d directed) and checked %0d results in %0d cycles.",
             sent, directed, checked, cycle_count);
    $display("Covered zero exponents, zero and unit moduli, unreduced bases %s",
             "and full-width operands.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
